>>> src/dd_pkg.sv
package dd_pkg;

  // Field widths
  localparam int TextWidth  = 48;
  localparam int DiffWidth  = 17;
  localparam int OrdWidth   = 16;
  localparam int MdayWidth  = 9;
  localparam int DecWidth   = 7;

  // Largest reachable magnitude of a difference (99 years of days plus slack)
  localparam int MaxSpan    = 36594;

  localparam logic [3:0]  MonthFeb   = 4'd2;
  localparam logic [3:0]  MonthDec   = 4'd12;
  localparam logic [15:0] YearDays   = 16'd365;

  // Input transaction: two dates as six ASCII digits YYMMDD
  typedef struct packed {
    logic [TextWidth-1:0] first_date_text;
    logic [TextWidth-1:0] second_date_text;
  } dd_in_t;

  // Result transaction
  typedef struct packed {
    logic signed [DiffWidth-1:0] day_difference;
    logic                        format_error;
  } dd_out_t;

  // One date after digit decode
  typedef struct packed {
    logic                err;
    logic [DecWidth-1:0] yy;
    logic [DecWidth-1:0] month;
    logic [DecWidth-1:0] day;
  } dd_dec_t;

  // Split day count after the first ordinal stage
  typedef struct packed {
    logic                 err;
    logic [OrdWidth-1:0]  year_days;
    logic [MdayWidth-1:0] month_days;
  } dd_part_t;

  // Day ordinal counted from the first day of year 2000
  typedef struct packed {
    logic                err;
    logic [OrdWidth-1:0] ord;
  } dd_ord_t;

  // Days before the first of the month in a common year
  function automatic logic [MdayWidth-1:0] month_start(input logic [3:0] m);
    logic [MdayWidth-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/date_difference_days.sv
// Channel  | Ports            | Handshake
// ---------+------------------+-------------------------------------------
// input    | start, request   | taken at a rising edge with start=1, busy=0
// output   | done, result     | one-cycle strobe, no back-pressure
//
// A transaction is taken every cycle while busy is low; its result passes
// through the register stages decode, year/month parts, ordinal, subtract.
// Reset clears the valid bits of all stages; busy is high only during reset.
// The receiver cannot stall, so the pipeline never holds.
module date_difference_days
  import dd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  dd_in_t  request,
  output logic    done,
  output dd_out_t result
);

  logic    accept;
  logic    v_dec;
  logic    v_part;
  logic    v_ord;
  dd_dec_t dec_a;
  dd_dec_t dec_b;
  dd_ord_t ord_a;
  dd_ord_t ord_b;
  dd_out_t result_next;

  assign busy   = rst;
  assign accept = start && !busy;

  dd_decode u_dec_a (.clk(clk), .text(request.first_date_text),  .dec(dec_a));
  dd_decode u_dec_b (.clk(clk), .text(request.second_date_text), .dec(dec_b));

  dd_ordinal u_ord_a (.clk(clk), .dec(dec_a), .ord(ord_a));
  dd_ordinal u_ord_b (.clk(clk), .dec(dec_b), .ord(ord_b));

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v_dec  <= 1'b0;
      v_part <= 1'b0;
      v_ord  <= 1'b0;
      done   <= 1'b0;
    end else begin
      v_dec  <= accept;
      v_part <= v_dec;
      v_ord  <= v_part;
      done   <= v_ord;
    end
  end

  // Subtract ordinals; force zero on a malformed date
  always_comb begin
    result_next.format_error = ord_a.err || ord_b.err;
    if (result_next.format_error) begin
      result_next.day_difference = '0;
    end else begin
      result_next.day_difference = signed'({1'b0, ord_a.ord} - {1'b0, ord_b.ord});
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

>>> src/dd_decode.sv
module dd_decode
  import dd_pkg::*;
(
  input  logic                 clk,
  input  logic [TextWidth-1:0] text,
  output dd_dec_t              dec
);

  logic [3:0] dig [6];
  logic [5:0] bad;
  dd_dec_t    dec_next;

  // Check each byte for an ASCII digit and strip the zone
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      dig[i] = text[(5-i)*8 +: 4];
      bad[i] = (text[(5-i)*8+4 +: 4] != 4'h3) || (text[(5-i)*8 +: 4] > 4'd9);
    end
  end

  // Combine digit pairs: tens * 10 + units
  always_comb begin
    dec_next.err   = |bad;
    dec_next.yy    = {dig[0], 3'b000} + {2'b00, dig[0], 1'b0} + {3'b000, dig[1]};
    dec_next.month = {dig[2], 3'b000} + {2'b00, dig[2], 1'b0} + {3'b000, dig[3]};
    dec_next.day   = {dig[4], 3'b000} + {2'b00, dig[4], 1'b0} + {3'b000, dig[5]};
  end

  always_ff @(posedge clk) begin
    dec <= dec_next;
  end

endmodule

>>> src/dd_ordinal.sv
module dd_ordinal
  import dd_pkg::*;
(
  input  logic    clk,
  input  dd_dec_t dec,
  output dd_ord_t ord
);

  dd_part_t part;
  dd_part_t part_next;
  dd_ord_t  ord_next;
  logic     month_bad;
  logic     leap_add;

  // Whole years since 2000 plus leap days; 2000..2099 is leap every fourth year
  always_comb begin
    month_bad = (dec.month == '0) || (dec.month > DecWidth'(MonthDec));
    leap_add  = (dec.month > DecWidth'(MonthFeb)) && (dec.yy[1:0] == 2'b00);
    part_next.err       = dec.err || month_bad;
    part_next.year_days = (OrdWidth'(dec.yy) * YearDays)
                        + OrdWidth'((8'(dec.yy) + 8'd3) >> 2);
    part_next.month_days = month_start(dec.month[3:0])
                         + MdayWidth'(leap_add)
                         + MdayWidth'(dec.day);
  end

  // Sum the year and month parts
  always_comb begin
    ord_next.err = part.err;
    ord_next.ord = part.year_days + OrdWidth'(part.month_days);
  end

  always_ff @(posedge clk) begin
    part <= part_next;
    ord  <= ord_next;
  end

endmodule

>>> src/dd_checker.sv
module dd_checker
  import dd_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input dd_out_t result
);

  // Every result comes from an earlier transaction taken while busy was low
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a matching transaction");

  // Every transaction not cut by reset yields a result
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    $past(start && !busy, 4) && !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3)
      |-> done)
    else $error("transaction dropped");

  // A malformed date gives a zero difference
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.format_error |-> result.day_difference == '0)
    else $error("nonzero difference with format error");

  // Difference stays within the span of the century
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.day_difference <= DiffWidth'(MaxSpan))
          && (result.day_difference >= -DiffWidth'(MaxSpan)))
    else $error("difference out of range");

endmodule

bind date_difference_days dd_checker u_dd_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .result(result)
);

>>> tb/date_difference_days_tb.sv
`timescale 1ns / 1ps

module date_difference_days_tb
  import dd_pkg::*;
();

  localparam int RandomPerPhase = 617;
  localparam int PipeLatency    = 4;

  logic    clk     = 1'b0;
  logic    rst     = 1'b1;
  logic    start   = 1'b0;
  dd_in_t  request = '0;
  logic    busy;
  logic    done;
  dd_out_t result;

  dd_in_t  pending_dates [$];
  dd_out_t expected_spans [$];
  dd_out_t span_want;

  int sender_idle_pct = 35;
  int mismatches      = 0;
  int spans_checked   = 0;
  int malformed_seen  = 0;
  int drain_cycles;

  date_difference_days u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #2 clk = ~clk;

  // Turn YYMMDD text into a day count; return 0 when the text is malformed
  function automatic bit days_since_epoch(input logic [TextWidth-1:0] text, output int days);
    logic [7:0] ch;
    int digit [6];
    int year, month, mday, py, mlen;
    bit leap;
    days = 0;
    for (int i = 0; i < 6; i++) begin
      ch = text[(5 - i) * 8 +: 8];
      if (ch < 8'h30 || ch > 8'h39) return 1'b0;
      digit[i] = ch - 8'h30;
    end
    year  = 2000 + digit[0] * 10 + digit[1];
    month = digit[2] * 10 + digit[3];
    mday  = digit[4] * 10 + digit[5];
    if (month < 1 || month > 12) return 1'b0;
    leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    py   = year - 1;
    days = py * 365 + py / 4 - py / 100 + py / 400;
    // add whole months before this one; day counts on linearly
    for (int m = 1; m < month; m++) begin
      if (m == 2) mlen = leap ? 29 : 28;
      else if (m == 4 || m == 6 || m == 9 || m == 11) mlen = 30;
      else mlen = 31;
      days += mlen;
    end
    days += mday;
    return 1'b1;
  endfunction

  // Expected result: first date minus second, or a flagged zero
  function automatic dd_out_t predict_span(input dd_in_t req);
    dd_out_t res;
    int a, b;
    bit ok_a, ok_b;
    logic [31:0] diff;
    res  = '0;
    ok_a = days_since_epoch(req.first_date_text, a);
    ok_b = days_since_epoch(req.second_date_text, b);
    if (!ok_a || !ok_b) begin
      res.format_error = 1'b1;
    end else begin
      diff = a - b;
      res.day_difference = diff[DiffWidth-1:0];
    end
    return res;
  endfunction

  function automatic logic [TextWidth-1:0] date_text(input int yy, input int mm, input int dd);
    logic [TextWidth-1:0] t;
    int v;
    t = '0;
    for (int i = 0; i < 3; i++) begin
      v = (i == 0) ? yy : ((i == 1) ? mm : dd);
      t = (t << 16) | ((8'h30 + v / 10) << 8) | (8'h30 + v % 10);
    end
    return t;
  endfunction

  // Mostly well-formed dates, some with a wild month, a bad byte, or pure noise
  function automatic logic [TextWidth-1:0] random_date_text();
    logic [TextWidth-1:0] t;
    int kind, dd;
    kind = $urandom_range(99);
    dd   = ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(31, 1);
    if (kind < 70) begin
      t = date_text($urandom_range(99), $urandom_range(12, 1), dd);
    end else if (kind < 80) begin
      t = date_text($urandom_range(99), $urandom_range(99), dd);
    end else if (kind < 90) begin
      t = date_text($urandom_range(99), $urandom_range(12, 1), dd);
      t[$urandom_range(5) * 8 +: 8] = 8'($urandom_range(255));
    end else begin
      t = TextWidth'({$urandom, $urandom});
    end
    return t;
  endfunction

  task automatic add_pair(input logic [TextWidth-1:0] a, input logic [TextWidth-1:0] b);
    dd_in_t r;
    r.first_date_text  = a;
    r.second_date_text = b;
    pending_dates.push_back(r);
  endtask

  // Driver: offer the next transaction, hold it until taken, idle at random
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_spans.push_back(predict_span(request));
      end
      if (!start || !busy) begin
        if (pending_dates.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start   <= 1'b1;
          request <= pending_dates.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_spans.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result day_difference=%0d format_error=%0b",
                 $time, $signed(result.day_difference), result.format_error);
      end else begin
        span_want = expected_spans.pop_front();
        spans_checked++;
        if (span_want.format_error) malformed_seen++;
        if (result.day_difference !== span_want.day_difference) begin
          mismatches++;
          $display("%0t: day_difference expected %0d actual %0d", $time,
                   $signed(span_want.day_difference), $signed(result.day_difference));
        end
        if (result.format_error !== span_want.format_error) begin
          mismatches++;
          $display("%0t: format_error expected %0b actual %0b", $time,
                   span_want.format_error, result.format_error);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    // equal dates, widest spans, leap and common February, day zero and day 99
    add_pair("000101", "000101");
    add_pair("991231", "000101");
    add_pair("000101", "991231");
    add_pair("991299", "000100");
    add_pair("000100", "991299");
    add_pair("000301", "000229");
    add_pair("010301", "010228");
    add_pair("040301", "040229");
    add_pair("991231", "981231");
    add_pair("960229", "961231");
    add_pair("001200", "001130");
    add_pair("000199", "000101");
    add_pair("990100", "981231");
    // malformed months and characters
    add_pair("000001", "000101");
    add_pair("001301", "000101");
    add_pair("000101", "999999");
    add_pair("/00101", "000101");
    add_pair("000101", "00010:");
    add_pair("00A101", "000101");
    add_pair(48'h0, 48'h0);
    add_pair('1, '1);
    add_pair("991299", '1);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      @(negedge clk);
      sender_idle_pct = (phase == 0) ? 35 : ((phase == 1) ? 62 : 0);
      for (int n = 0; n < RandomPerPhase; n++) begin
        add_pair(random_date_text(), random_date_text());
      end
      while (pending_dates.size() != 0) @(negedge clk);
    end

    // drain: last transaction taken, then every result in
    while (pending_dates.size() != 0 || start) @(negedge clk);
    drain_cycles = 0;
    while (expected_spans.size() != 0 && drain_cycles < 200) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (2 * PipeLatency) @(negedge clk);
    if (expected_spans.size() != 0) begin
      mismatches += expected_spans.size();
      $display("%0t: %0d results never arrived", $time, expected_spans.size());
    end

    $display("Checked %0d date-pair results across 35%%, 62%% and no sender idling.",
             spans_checked);
    $display("%0d of them were flagged malformed, %0d mismatches.", malformed_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #200_000;
    $display("%0t: timeout", $time);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
src/dd_pkg.sv
src/dd_decode.sv
src/dd_ordinal.sv
src/date_difference_days.sv
src/dd_checker.sv
tb/date_difference_days_tb.sv
